[rtl/positional_list_store_assert.svh]
// Assertion macros shared by the checker modules of the positional list store.
// Each macro places one labelled concurrent assertion, clocked on i_clk and
// switched off while i_rst_n is low.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/plst_pkg.sv]
// ----------------------------------------------------------------------------
// plst_pkg: shared definitions of the positional list store
// Sizes, operation and status codes, and the command and status structs that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

    localparam int CAPACITY  = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;
    localparam int CMP_W     = POS_W + 1;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 48;

    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic op_go;   // an input transfer is taken this cycle
        logic rd_go;   // emit the next stored value of a read-out
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the output register can be loaded this cycle
        logic multi;     // more than one value is stored
        logic rd_final;  // the next read-out value is the last one
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/positional_list_store.sv]
// ----------------------------------------------------------------------------
// positional_list_store: ordered store of signed 32-bit values
// Append, insert at a 1-based position, delete at a position and read-out of
// all stored values in order, each update answered with a status.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the operation, tdata the position and value.
//   Output stream: tdata carries the value, status and entry count; tlast
//   marks the final result of each input transfer.
//   Append, insert and delete each give one result, held in an output
//   register; a new transfer is taken every cycle as long as no read-out
//   is in progress and that register is free or emptied in the same cycle.
//   The result is registered and appears in the cycle after the input transfer.
//   A read-out of n values gives n results: the first value leaves with the
//   accepting transfer and the shift cells are then read one per cycle while
//   the output register is free, input held off until the last value is
//   issued. An empty read-out gives one result with status empty.
//   When the receiver stalls, the result register holds and the input side
//   is held off; nothing is lost.
//   Reset empties the store and drops any pending result; no clearing pass
//   is needed since only written cells are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: position [6:0], value [38:7], zero [39]
    input  wire logic [plst_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // tuser: func [1:0]
    input  wire logic [plst_pkg::FUNC_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: item_value [31:0], status [33:32], entries [40:34], zero [47:41]
    output logic [plst_pkg::M_DATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int VAL_LO = plst_pkg::POS_W;
    localparam int ENT_LO = plst_pkg::VAL_W + plst_pkg::STATUS_W;
    localparam int PAD_W  = plst_pkg::M_DATA_W - ENT_LO - plst_pkg::ENTRIES_W;

    plst_pkg::t_dp_cmd                 cmd;
    plst_pkg::t_dp_sts                 sts;
    logic signed [plst_pkg::VAL_W-1:0] item_value;
    logic [plst_pkg::STATUS_W-1:0]     status;
    logic [plst_pkg::ENTRIES_W-1:0]    entries;

    plst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    plst_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (s_axis_tuser),
        .i_position   (s_axis_tdata[plst_pkg::POS_W-1:0]),
        .i_value      (s_axis_tdata[VAL_LO +: plst_pkg::VAL_W]),
        .i_m_tready   (m_axis_tready),
        .o_sts        (sts),
        .o_m_tvalid   (m_axis_tvalid),
        .o_item_value (item_value),
        .o_status     (status),
        .o_entries    (entries),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, entries, status, item_value};

endmodule

`default_nettype wire

[rtl/plst_ctrl.sv]
// ----------------------------------------------------------------------------
// plst_ctrl: sequencer of the positional list store
// Takes input transfers while idle; steps a read-out through the stored values
// one per cycle while the output is free, holding input off until the last is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    input  wire logic [plst_pkg::FUNC_W-1:0]   i_func,
    input  wire plst_pkg::t_dp_sts             i_sts,
    output logic                               o_s_tready,
    output plst_pkg::t_dp_cmd                  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd.op_go  = 1'b0;
        o_cmd.rd_go  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready  = i_sts.out_free;
                o_cmd.op_go = i_s_tvalid && i_sts.out_free;
                // The first value of a read-out leaves with the accepting transfer.
                if (o_cmd.op_go && (i_func == plst_pkg::FN_READ) && i_sts.multi) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_go = i_sts.out_free;
                if (o_cmd.rd_go && i_sts.rd_final) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/plst_dp.sv]
// ----------------------------------------------------------------------------
// plst_dp: datapath of the positional list store
// A row of shift cells with a fill count, the read-out index and the output
// register that holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire plst_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [plst_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [plst_pkg::POS_W-1:0]        i_position,
    input  wire logic signed [plst_pkg::VAL_W-1:0] i_value,
    input  wire logic                              i_m_tready,
    output plst_pkg::t_dp_sts                      o_sts,
    output logic                                   o_m_tvalid,
    output logic signed [plst_pkg::VAL_W-1:0]      o_item_value,
    output logic [plst_pkg::STATUS_W-1:0]          o_status,
    output logic [plst_pkg::ENTRIES_W-1:0]         o_entries,
    output logic                                   o_last
);

    logic signed [plst_pkg::VAL_W-1:0] r_cells [plst_pkg::CAPACITY];
    logic [plst_pkg::CNT_W-1:0]        r_count;
    logic [plst_pkg::CNT_W-1:0]        n_count;
    logic [plst_pkg::IDX_W-1:0]        r_rd_idx;

    logic                               r_out_valid;
    logic signed [plst_pkg::VAL_W-1:0]  r_out_item;
    logic [plst_pkg::STATUS_W-1:0]      r_out_status;
    logic [plst_pkg::ENTRIES_W-1:0]     r_out_entries;
    logic                               r_out_last;

    logic [plst_pkg::STATUS_W-1:0] n_status;
    logic                          append_ok;
    logic                          insert_ok;
    logic                          delete_ok;
    logic [plst_pkg::CMP_W-1:0]    pos_ext;
    logic [plst_pkg::CMP_W-1:0]    cnt_ext;
    logic [plst_pkg::CMP_W-1:0]    slot;
    logic                          is_empty;
    logic                          is_full;

    assign pos_ext  = plst_pkg::CMP_W'(i_position);
    assign cnt_ext  = plst_pkg::CMP_W'(r_count);
    assign slot     = pos_ext - plst_pkg::CMP_W'(1);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == plst_pkg::CNT_W'(plst_pkg::CAPACITY));

    always_comb begin
        n_status  = plst_pkg::STS_OK;
        n_count   = r_count;
        append_ok = 1'b0;
        insert_ok = 1'b0;
        delete_ok = 1'b0;
        case (i_func)
            plst_pkg::FN_APPEND: begin
                if (is_full) begin
                    n_status = plst_pkg::STS_FULL;
                end else begin
                    append_ok = 1'b1;
                    n_count   = r_count + plst_pkg::CNT_W'(1);
                end
            end
            plst_pkg::FN_INSERT: begin
                if (is_empty) begin
                    n_status = plst_pkg::STS_EMPTY;
                end else if (is_full) begin
                    n_status = plst_pkg::STS_FULL;
                end else if ((pos_ext == '0) || (pos_ext > cnt_ext + plst_pkg::CMP_W'(1))) begin
                    n_status = plst_pkg::STS_NOT_FOUND;
                end else begin
                    insert_ok = 1'b1;
                    n_count   = r_count + plst_pkg::CNT_W'(1);
                end
            end
            plst_pkg::FN_DELETE: begin
                if (is_empty) begin
                    n_status = plst_pkg::STS_EMPTY;
                end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                    n_status = plst_pkg::STS_NOT_FOUND;
                end else begin
                    delete_ok = 1'b1;
                    n_count   = r_count - plst_pkg::CNT_W'(1);
                end
            end
            plst_pkg::FN_READ: begin
                if (is_empty) begin
                    n_status = plst_pkg::STS_EMPTY;
                end
            end
            default: begin
                n_status = plst_pkg::STS_OK;
            end
        endcase
    end

    // Every cell looks only at its own neighbours, so insert and delete
    // complete in the cycle of the transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op_go) begin
            for (int i = 1; i < plst_pkg::CAPACITY; i++) begin
                if (insert_ok && (plst_pkg::CMP_W'(i) > slot)) begin
                    r_cells[i] <= r_cells[i-1];
                end
            end
            for (int i = 0; i < plst_pkg::CAPACITY - 1; i++) begin
                if (delete_ok && (plst_pkg::CMP_W'(i) >= slot)) begin
                    r_cells[i] <= r_cells[i+1];
                end
            end
            for (int i = 0; i < plst_pkg::CAPACITY; i++) begin
                if ((insert_ok && (plst_pkg::CMP_W'(i) == slot)) ||
                    (append_ok && (plst_pkg::CNT_W'(i) == r_count))) begin
                    r_cells[i] <= i_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op_go) begin
                r_count <= n_count;
            end
            if (i_cmd.op_go || i_cmd.rd_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_go) begin
            r_rd_idx      <= plst_pkg::IDX_W'(1);
            r_out_status  <= n_status;
            r_out_entries <= plst_pkg::ENTRIES_W'(n_count);
            if ((i_func == plst_pkg::FN_READ) && !is_empty) begin
                r_out_item <= r_cells[0];
                r_out_last <= !o_sts.multi;
            end else begin
                r_out_item <= '0;
                r_out_last <= 1'b1;
            end
        end else if (i_cmd.rd_go) begin
            r_rd_idx      <= r_rd_idx + plst_pkg::IDX_W'(1);
            r_out_item    <= r_cells[r_rd_idx];
            r_out_status  <= plst_pkg::STS_OK;
            r_out_entries <= plst_pkg::ENTRIES_W'(r_count);
            r_out_last    <= o_sts.rd_final;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_sts.multi    = (r_count > plst_pkg::CNT_W'(1));
    assign o_sts.rd_final = ((plst_pkg::CNT_W'(r_rd_idx) + plst_pkg::CNT_W'(1)) == r_count);

    assign o_m_tvalid   = r_out_valid;
    assign o_item_value = r_out_item;
    assign o_status     = r_out_status;
    assign o_entries    = r_out_entries;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

[rtl/plst_checker.sv]
// ----------------------------------------------------------------------------
// plst_checker: port-level checks of the positional list store
// Watches the two stream channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_store_assert.svh"

module plst_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [plst_pkg::S_DATA_W-1:0] s_axis_tdata,
    input wire logic [plst_pkg::FUNC_W-1:0]   s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [plst_pkg::M_DATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast
);

    logic [plst_pkg::STATUS_W-1:0]  mon_status;
    logic [plst_pkg::ENTRIES_W-1:0] mon_entries;
    logic                           mon_in_seen;

    assign mon_status  = m_axis_tdata[plst_pkg::VAL_W +: plst_pkg::STATUS_W];
    assign mon_entries = m_axis_tdata[plst_pkg::VAL_W + plst_pkg::STATUS_W +: plst_pkg::ENTRIES_W];
    // Input fields are only observed here; they take part in no check.
    assign mon_in_seen = s_axis_tvalid && (|s_axis_tdata || |s_axis_tuser);

    // A stalled result stays in place.
    `PLST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled result changed")

    // No new input is taken while a result waits for the receiver.
    `PLST_ASSERT_SAME(a_no_take_on_stall, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready, "input taken while the output is stalled")

    // The entry count never exceeds the capacity.
    `PLST_ASSERT_SAME(a_entries_range, m_axis_tvalid,
        mon_entries <= plst_pkg::ENTRIES_W'(plst_pkg::CAPACITY),
        "entry count above capacity")

    // Only a read-out gives results without tlast, and those carry status ok.
    `PLST_ASSERT_SAME(a_readout_ok, m_axis_tvalid && !m_axis_tlast && !mon_in_seen ||
        m_axis_tvalid && !m_axis_tlast && mon_in_seen,
        mon_status == plst_pkg::STS_OK, "read-out result with a failing status")

endmodule

bind positional_list_store plst_checker u_plst_checker (.*);

`default_nettype wire

[verif/tb_positional_list_store.sv]
// ----------------------------------------------------------------------------
// tb_positional_list_store: self-checking bench for the positional list store
// Operations are queued up front, a short directed set first and then random
// phases that fill, churn and drain the store. A local model of the ordered
// list predicts every result when an input transfer is taken, and each output
// transfer is compared field by field with the oldest prediction. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------

module tb_positional_list_store;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [plst_pkg::FUNC_W-1:0] func;
        logic [plst_pkg::POS_W-1:0]  pos;
        logic [plst_pkg::VAL_W-1:0]  value;
    } t_list_op;

    typedef struct {
        logic [plst_pkg::VAL_W-1:0]     item_value;
        logic [plst_pkg::STATUS_W-1:0]  status;
        logic [plst_pkg::ENTRIES_W-1:0] entries;
        logic                           last_flag;
    } t_list_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [plst_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [plst_pkg::FUNC_W-1:0]     s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [plst_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tlast;

    t_list_op                   pending_ops[$];
    t_list_result               expected_results[$];
    logic [plst_pkg::VAL_W-1:0] stored_values[$];

    int err_count = 0;
    int cycle_count = 0;
    int gen_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_mode = 0;
    int mode_left = 0;
    int stall_left = 0;

    positional_list_store u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_expected(logic [plst_pkg::VAL_W-1:0] item_value,
                                          logic [plst_pkg::STATUS_W-1:0] status,
                                          logic last_flag);
        t_list_result res;
        res.item_value = item_value;
        res.status     = status;
        res.entries    = plst_pkg::ENTRIES_W'(stored_values.size());
        res.last_flag  = last_flag;
        expected_results.push_back(res);
    endfunction

    // Updates the local list for one taken operation and queues its results.
    function automatic void apply_list_op(t_list_op op);
        int n;
        int p;
        logic [plst_pkg::STATUS_W-1:0] sts;
        n = stored_values.size();
        p = int'(op.pos);
        sts = plst_pkg::STS_OK;
        case (op.func)
            plst_pkg::FN_READ: begin
                if (n == 0) begin
                    push_expected('0, plst_pkg::STS_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        push_expected(stored_values[i], plst_pkg::STS_OK, i == n - 1);
                end
                return;
            end
            plst_pkg::FN_APPEND: begin
                if (n >= plst_pkg::CAPACITY) sts = plst_pkg::STS_FULL;
                else stored_values.push_back(op.value);
            end
            plst_pkg::FN_INSERT: begin
                if (n == 0) sts = plst_pkg::STS_EMPTY;
                else if (n >= plst_pkg::CAPACITY) sts = plst_pkg::STS_FULL;
                else if (p == 0 || p > n + 1) sts = plst_pkg::STS_NOT_FOUND;
                else stored_values.insert(p - 1, op.value);
            end
            default: begin
                if (n == 0) sts = plst_pkg::STS_EMPTY;
                else if (p == 0 || p > n) sts = plst_pkg::STS_NOT_FOUND;
                else stored_values.delete(p - 1);
            end
        endcase
        push_expected('0, sts, 1'b1);
    endfunction

    // The generator keeps its own fill level so that positions can be aimed
    // at the stored range most of the time.
    task automatic queue_op(logic [plst_pkg::FUNC_W-1:0] func, int pos,
                            logic [plst_pkg::VAL_W-1:0] value);
        t_list_op op;
        op.func  = func;
        op.pos   = plst_pkg::POS_W'(pos);
        op.value = value;
        pending_ops.push_back(op);
        case (func)
            plst_pkg::FN_APPEND: if (gen_count < plst_pkg::CAPACITY) gen_count++;
            plst_pkg::FN_INSERT: begin
                if (gen_count > 0 && gen_count < plst_pkg::CAPACITY &&
                    pos >= 1 && pos <= gen_count + 1)
                    gen_count++;
            end
            plst_pkg::FN_DELETE: if (gen_count > 0 && pos >= 1 && pos <= gen_count) gen_count--;
            default: ;
        endcase
    endtask

    function automatic int pick_position(bit for_insert);
        int top;
        top = for_insert ? gen_count + 1 : gen_count;
        if (gen_count == 0) return $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, top);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return (top + 1 <= 65) ? $urandom_range(top + 1, 65) : 0;
            default: return $urandom_range(64, 65);
        endcase
    endfunction

    function automatic logic [plst_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Weights per phase: append, insert, delete, with read-out taking the rest.
    task automatic queue_phase(int count, int w_app, int w_ins, int w_del);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < w_app)
                queue_op(plst_pkg::FN_APPEND, $urandom_range(0, 65), pick_value());
            else if (r < w_app + w_ins)
                queue_op(plst_pkg::FN_INSERT, pick_position(1'b1), pick_value());
            else if (r < w_app + w_ins + w_del)
                queue_op(plst_pkg::FN_DELETE, pick_position(1'b0), pick_value());
            else
                queue_op(plst_pkg::FN_READ, $urandom_range(0, 65), pick_value());
        end
    endtask

    // Stimulus is built at time zero, then the run is watched to its end.
    initial begin
        queue_op(plst_pkg::FN_READ,   0,  32'h0);
        queue_op(plst_pkg::FN_INSERT, 1,  32'h1234_5678);
        queue_op(plst_pkg::FN_DELETE, 1,  32'h0);
        queue_op(plst_pkg::FN_APPEND, 0,  32'h8000_0000);
        queue_op(plst_pkg::FN_DELETE, 0,  32'h0);
        queue_op(plst_pkg::FN_DELETE, 2,  32'h0);
        queue_op(plst_pkg::FN_DELETE, 1,  32'h0);
        queue_op(plst_pkg::FN_APPEND, 65, 32'h7FFF_FFFF);
        queue_op(plst_pkg::FN_INSERT, 1,  32'h0000_0000);
        queue_op(plst_pkg::FN_INSERT, 3,  32'hFFFF_FFFF);
        queue_op(plst_pkg::FN_INSERT, 0,  32'h5555_5555);
        queue_op(plst_pkg::FN_INSERT, 5,  32'hAAAA_AAAA);
        queue_op(plst_pkg::FN_INSERT, 64, 32'hAAAA_AAAA);
        queue_op(plst_pkg::FN_READ,   127 - 62, 32'hFFFF_FFFF);
        queue_op(plst_pkg::FN_DELETE, 3,  32'h0);
        queue_op(plst_pkg::FN_DELETE, 65, 32'h0);
        queue_op(plst_pkg::FN_READ,   0,  32'h0);

        queue_phase(45, 55, 30, 8);
        queue_phase(35, 30, 30, 30);
        queue_phase(50, 10, 10, 68);
        queue_phase(40, 55, 30, 8);
        queue_phase(30, 30, 30, 30);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_positional_list_store OK");
        end else begin
            $display("tb_positional_list_store NOT OK");
        end
        $finish;
    end

    // Input side: bursts of transfers separated by random gaps.
    always @(posedge i_clk) begin
        logic taken;
        taken = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            if (taken) apply_list_op(pending_ops.pop_front());
            if (s_axis_tvalid && !taken) begin
                // Offered transfer still waiting, hold it.
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, pending_ops[0].value, pending_ops[0].pos};
                s_axis_tuser  <= pending_ops[0].func;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: check each transfer, then pick the next ready value from a
    // stall pattern whose character is redrawn at random.
    always @(posedge i_clk) begin
        t_list_result                   want;
        logic [plst_pkg::VAL_W-1:0]     got_value;
        logic [plst_pkg::STATUS_W-1:0]  got_status;
        logic [plst_pkg::ENTRIES_W-1:0] got_entries;
        got_value   = m_axis_tdata[31:0];
        got_status  = m_axis_tdata[33:32];
        got_entries = m_axis_tdata[40:34];
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result value=%h status=%0d entries=%0d last=%b",
                         $time, got_value, got_status, got_entries, m_axis_tlast);
            end else begin
                want = expected_results.pop_front();
                if (got_value !== want.item_value) begin
                    err_count++;
                    $display("%0t: item_value expected %h actual %h",
                             $time, want.item_value, got_value);
                end
                if (got_status !== want.status) begin
                    err_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got_status);
                end
                if (got_entries !== want.entries) begin
                    err_count++;
                    $display("%0t: entries expected %0d actual %0d",
                             $time, want.entries, got_entries);
                end
                if (m_axis_tlast !== want.last_flag) begin
                    err_count++;
                    $display("%0t: tlast expected %b actual %b",
                             $time, want.last_flag, m_axis_tlast);
                end
            end
        end

        if (mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 2);
                2: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(3, 8);
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("tb_positional_list_store NOT OK");
            $finish;
        end
    end

endmodule

[sim.f]
+incdir+rtl
rtl/plst_pkg.sv
rtl/plst_ctrl.sv
rtl/plst_dp.sv
rtl/positional_list_store.sv
rtl/plst_checker.sv
verif/tb_positional_list_store.sv
